### hdl/sprite_pixel_collision_defines.svh
// Assertion helpers for the sprite collision block.
`ifndef SPRITE_PIXEL_COLLISION_DEFINES_SVH
`define SPRITE_PIXEL_COLLISION_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

    localparam int MAX_W = 16;
    localparam int MAX_H = 16;

    localparam int MODE_W      = 2;
    localparam int ROW_INDEX_W = 4;
    localparam int ROW_BITS_W  = 16;
    localparam int POS_W       = 10;
    localparam int SIZE_W      = 5;

    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;

    localparam int ROW_IW = (MAX_H > 1) ? $clog2(MAX_H) : 1;
    localparam int CNT_W  = $clog2(MAX_H + 1);
    localparam int SZW_W  = $clog2(MAX_W + 1);
    localparam int SH_W   = (MAX_W > 1) ? $clog2(MAX_W) : 1;

    localparam int DIFF_W = POS_W + 1;
    localparam int RB_W   = POS_W + 2;

endpackage

### hdl/spc_if.sv
`timescale 1ns / 1ps

interface spc_req_if import spc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic        [MODE_W-1:0]      mode;
    logic        [ROW_INDEX_W-1:0] row_index;
    logic        [ROW_BITS_W-1:0]  row_bits;
    logic signed [POS_W-1:0]       ax;
    logic signed [POS_W-1:0]       ay;
    logic        [SIZE_W-1:0]      aw;
    logic        [SIZE_W-1:0]      ah;
    logic signed [POS_W-1:0]       bx;
    logic signed [POS_W-1:0]       by;
    logic        [SIZE_W-1:0]      bw;
    logic        [SIZE_W-1:0]      bh;

    modport source (
        output valid, mode, row_index, row_bits, ax, ay, aw, ah, bx, by, bw, bh,
        input  ready
    );
    modport sink (
        input  valid, mode, row_index, row_bits, ax, ay, aw, ah, bx, by, bw, bh,
        output ready
    );
endinterface

interface spc_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

### hdl/sprite_pixel_collision.sv
`timescale 1ns / 1ps
// Pixel-exact collision test between two one-bit sprite masks.
// req (sink): one item per valid/ready handshake. mode selects a row load
//   into mask A, a row load into mask B, or a collision test; mode three is
//   dropped. Row loads finish in the accept cycle and give no result.
// rsp (source): one hit item per test, held in an output register until the
//   receiver takes it.
// A test scans sprite A one row per cycle through a single shift/AND unit
//   (ah clamped to MAX_H), then passes through the done step; the result is
//   valid in the same cycle that req is ready again. The row count of
//   sprite A sets the scan length.
// Loads are accepted whenever the sequencer is idle, also while a result waits.
// If a previous result is still not taken when a scan ends, the block holds
//   the new result and stays not ready until the output register frees up.
// Reset clears the sequencer and the output valid; mask rows read as
//   undefined until loaded.
module sprite_pixel_collision
    import spc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    spc_req_if.sink   req,
    spc_rsp_if.source rsp
);

`include "sprite_pixel_collision_defines.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [CNT_W-1:0] scan_row_reg, scan_row_next;
    logic hit_reg, hit_next;
    logic out_valid_reg, out_valid_next;
    logic out_hit_reg, out_hit_next;

    logic [MAX_W-1:0] mask_a_reg [MAX_H];
    logic [MAX_W-1:0] mask_b_reg [MAX_H];

    logic [SZW_W-1:0] aw_reg, bw_reg;
    logic [CNT_W-1:0] ah_reg, bh_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic signed [DIFF_W-1:0] rb0_reg;

    logic [SZW_W-1:0] aw_clamp, bw_clamp;
    logic [CNT_W-1:0] ah_clamp, bh_clamp;

    logic in_fire, load_ok;
    logic [MAX_W-1:0] load_bits;
    logic [ROW_IW-1:0] load_idx;

    logic signed [RB_W-1:0] rb;
    logic rb_ok;
    logic [MAX_W-1:0] amask, bmask, ra, rbits, rshift;
    logic [DIFF_W-1:0] d_mag;
    logic d_far;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.hit   = out_hit_reg;

    assign aw_clamp = (int'(req.aw) > MAX_W) ? SZW_W'(MAX_W) : SZW_W'(req.aw);
    assign bw_clamp = (int'(req.bw) > MAX_W) ? SZW_W'(MAX_W) : SZW_W'(req.bw);
    assign ah_clamp = (int'(req.ah) > MAX_H) ? CNT_W'(MAX_H) : CNT_W'(req.ah);
    assign bh_clamp = (int'(req.bh) > MAX_H) ? CNT_W'(MAX_H) : CNT_W'(req.bh);

    assign load_ok   = (int'(req.row_index) < MAX_H);
    assign load_idx  = ROW_IW'(req.row_index);
    assign load_bits = MAX_W'(req.row_bits);

    always_ff @(posedge clk)
    begin
        if (in_fire && load_ok && req.mode == MODE_LOAD_A)
        begin
            mask_a_reg[load_idx] <= load_bits;
        end
        if (in_fire && load_ok && req.mode == MODE_LOAD_B)
        begin
            mask_b_reg[load_idx] <= load_bits;
        end
        if (in_fire && req.mode == MODE_TEST)
        begin
            aw_reg  <= aw_clamp;
            bw_reg  <= bw_clamp;
            ah_reg  <= ah_clamp;
            bh_reg  <= bh_clamp;
            d_reg   <= DIFF_W'(req.bx) - DIFF_W'(req.ax);
            rb0_reg <= DIFF_W'(req.ay) - DIFF_W'(req.by);
        end
    end

    // One row of the scan: align B's row to A's columns and AND.
    always_comb
    begin
        for (int i = 0; i < MAX_W; i++)
        begin
            amask[i] = (SZW_W'(i) < aw_reg);
            bmask[i] = (SZW_W'(i) < bw_reg);
        end
        rb    = RB_W'(rb0_reg) + $signed(RB_W'(scan_row_reg));
        rb_ok = !rb[RB_W-1] && (rb[RB_W-2:0] < (RB_W-1)'(bh_reg));
        ra    = mask_a_reg[scan_row_reg[ROW_IW-1:0]] & amask;
        rbits = mask_b_reg[rb[ROW_IW-1:0]] & bmask;
        d_mag = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
        d_far = (d_mag >= DIFF_W'(MAX_W));
        if (d_far)
        begin
            rshift = '0;
        end
        else if (!d_reg[DIFF_W-1])
        begin
            rshift = rbits << d_mag[SH_W-1:0];
        end
        else
        begin
            rshift = rbits >> d_mag[SH_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_row_next  = scan_row_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && req.mode == MODE_TEST)
                begin
                    state_next    = ST_SCAN;
                    scan_row_next = '0;
                    hit_next      = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_row_reg == ah_reg)
                begin
                    state_next    = ST_DONE;
                    scan_row_next = '0;
                end
                else
                begin
                    scan_row_next = scan_row_reg + 1'b1;
                    if (rb_ok && ((ra & rshift) != '0))
                    begin
                        hit_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_row_reg  <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_row_reg  <= scan_row_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg <= out_hit_next;
    end

    `SPC_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN,
        scan_row_reg <= ah_reg, "scan row past sprite height")
    `SPC_ASSERT_NEXT(a_test_starts_scan, clk, rst_n,
        req.valid && req.ready && req.mode == MODE_TEST,
        state_reg == ST_SCAN && scan_row_reg == '0, "test item did not start a scan")
    `SPC_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(rsp.valid),
        $past(state_reg) == ST_DONE, "result raised outside done step")
    `SPC_ASSERT_NOW(a_idle_counter_clear, clk, rst_n, state_reg != ST_SCAN,
        scan_row_reg == '0, "row counter not cleared between items")

endmodule

### verif/spc_hit_checker.sv
`timescale 1ns / 1ps

module spc_hit_checker
    import spc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spc_req_if   req,
    spc_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   hits_predicted
);

    logic [MAX_W-1:0] sprite_a [MAX_H];
    logic [MAX_W-1:0] sprite_b [MAX_H];
    logic             expected_hits [$];
    int               n_fail = 0;
    int               n_pending = 0;
    int               n_hits = 0;

    assign fail_count     = n_fail;
    assign pending        = n_pending;
    assign hits_predicted = n_hits;

    function automatic int clamp_size(input logic [SIZE_W-1:0] raw, input int lim);
        return (int'(raw) > lim) ? lim : int'(raw);
    endfunction

    function automatic logic overlap_hit(
        input logic signed [POS_W-1:0]  ax,
        input logic signed [POS_W-1:0]  ay,
        input logic        [SIZE_W-1:0] aw_raw,
        input logic        [SIZE_W-1:0] ah_raw,
        input logic signed [POS_W-1:0]  bx,
        input logic signed [POS_W-1:0]  by,
        input logic        [SIZE_W-1:0] bw_raw,
        input logic        [SIZE_W-1:0] bh_raw
    );
        int               aw;
        int               ah;
        int               bw;
        int               bh;
        int               d;
        int               rb;
        logic [MAX_W-1:0] amask;
        logic [MAX_W-1:0] bmask;
        logic [MAX_W-1:0] ra;
        logic [MAX_W-1:0] rbits;
        logic             found;
        aw    = clamp_size(aw_raw, MAX_W);
        ah    = clamp_size(ah_raw, MAX_H);
        bw    = clamp_size(bw_raw, MAX_W);
        bh    = clamp_size(bh_raw, MAX_H);
        amask = '1;
        amask = amask >> (MAX_W - aw);
        bmask = '1;
        bmask = bmask >> (MAX_W - bw);
        d     = int'(bx) - int'(ax);
        found = 1'b0;
        for (int r = 0; r < ah; r++)
        begin
            rb = int'(ay) + r - int'(by);
            if (rb >= 0 && rb < bh)
            begin
                ra    = sprite_a[r] & amask;
                rbits = sprite_b[rb] & bmask;
                if (d >= MAX_W || d <= -MAX_W)
                    rbits = '0;
                else if (d >= 0)
                    rbits = rbits << d;
                else
                    rbits = rbits >> (-d);
                if ((ra & rbits) != '0)
                    found = 1'b1;
            end
        end
        return found;
    endfunction

    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            // results leave before a new test enters the queue
            if (rsp.valid && rsp.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected result: hit %0b with no test pending", rsp.hit);
                    n_fail++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (rsp.hit !== want)
                    begin
                        $error("hit mismatch: expected %0b, actual %0b", want, rsp.hit);
                        n_fail++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.mode)
                    MODE_LOAD_A:
                        if (int'(req.row_index) < MAX_H)
                            sprite_a[req.row_index] = req.row_bits[MAX_W-1:0];
                    MODE_LOAD_B:
                        if (int'(req.row_index) < MAX_H)
                            sprite_b[req.row_index] = req.row_bits[MAX_W-1:0];
                    MODE_TEST:
                    begin
                        want = overlap_hit(req.ax, req.ay, req.aw, req.ah,
                                           req.bx, req.by, req.bw, req.bh);
                        expected_hits.push_back(want);
                        if (want)
                            n_hits++;
                    end
                    default:
                        ;
                endcase
            end
            n_pending <= expected_hits.size();
        end
    end

endmodule

### verif/sprite_pixel_collision_tb.sv
`timescale 1ns / 1ps

module sprite_pixel_collision_tb;
    import spc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int                N_RANDOM  = 1700;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [ROW_INDEX_W-1:0] row_index;
        logic [ROW_BITS_W-1:0]  row_bits;
        logic [POS_W-1:0]       ax;
        logic [POS_W-1:0]       ay;
        logic [SIZE_W-1:0]      aw;
        logic [SIZE_W-1:0]      ah;
        logic [POS_W-1:0]       bx;
        logic [POS_W-1:0]       by;
        logic [SIZE_W-1:0]      bw;
        logic [SIZE_W-1:0]      bh;
    } sprite_item_t;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   rsp_taken;
    int   stall_left;
    int   fail_count;
    int   pending;
    int   hits_predicted;
    int   n_tests;
    int   n_loads;
    int   n_dropped;

    spc_req_if req_if ();
    spc_rsp_if rsp_if ();

    sprite_pixel_collision dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    spc_hit_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_if),
        .rsp            (rsp_if),
        .fail_count     (fail_count),
        .pending        (pending),
        .hits_predicted (hits_predicted)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
        rsp_taken <= rsp_if.valid && rsp_if.ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
                stall_left = calm ? 0 : $urandom_range(0, 17);
            if (stall_left > 0)
            begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready = 1'b1;
        end
    end

    function automatic sprite_item_t noise_item();
        sprite_item_t it;
        it = $bits(sprite_item_t)'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    function automatic sprite_item_t load_item(input logic [MODE_W-1:0] mode,
                                               input int row,
                                               input logic [ROW_BITS_W-1:0] bits);
        sprite_item_t it;
        it           = noise_item();
        it.mode      = mode;
        it.row_index = ROW_INDEX_W'(row);
        it.row_bits  = bits;
        return it;
    endfunction

    function automatic sprite_item_t test_item(input int ax, input int ay,
                                               input int aw, input int ah,
                                               input int bx, input int by,
                                               input int bw, input int bh);
        sprite_item_t it;
        it      = noise_item();
        it.mode = MODE_TEST;
        it.ax   = POS_W'(ax);
        it.ay   = POS_W'(ay);
        it.aw   = SIZE_W'(aw);
        it.ah   = SIZE_W'(ah);
        it.bx   = POS_W'(bx);
        it.by   = POS_W'(by);
        it.bw   = SIZE_W'(bw);
        it.bh   = SIZE_W'(bh);
        return it;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        if ($urandom_range(0, 4) == 0)
            return SIZE_W'($urandom_range(0, 31));
        return SIZE_W'($urandom_range(1, MAX_W));
    endfunction

    function automatic logic [ROW_BITS_W-1:0] rand_row();
        case ($urandom_range(0, 3))
            0: return '1;
            1: return ROW_BITS_W'($urandom & $urandom & $urandom);
            2: return ROW_BITS_W'($urandom | $urandom);
            default: return ROW_BITS_W'($urandom);
        endcase
    endfunction

    function automatic sprite_item_t random_item();
        sprite_item_t it;
        int           pick;
        it   = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            it.mode = MODE_NONE;
        else if (pick < 45)
        begin
            it.mode     = pick[0] ? MODE_LOAD_A : MODE_LOAD_B;
            it.row_bits = rand_row();
        end
        else
        begin
            it.mode = MODE_TEST;
            it.aw   = rand_size();
            it.ah   = rand_size();
            it.bw   = rand_size();
            it.bh   = rand_size();
            // mostly nearby boxes so overlaps are common
            if ($urandom_range(0, 9) != 0)
            begin
                it.bx = it.ax + POS_W'($urandom_range(0, 40)) - POS_W'(20);
                it.by = it.ay + POS_W'($urandom_range(0, 40)) - POS_W'(20);
            end
        end
        return it;
    endfunction

    task automatic drive(input sprite_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.mode      = it.mode;
        req_if.row_index = it.row_index;
        req_if.row_bits  = it.row_bits;
        req_if.ax        = it.ax;
        req_if.ay        = it.ay;
        req_if.aw        = it.aw;
        req_if.ah        = it.ah;
        req_if.bx        = it.bx;
        req_if.by        = it.by;
        req_if.bw        = it.bw;
        req_if.bh        = it.bh;
        req_if.valid     = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        case (it.mode)
            MODE_TEST:               n_tests++;
            MODE_LOAD_A, MODE_LOAD_B: n_loads++;
            default:                 n_dropped++;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        #3000000;
        $display("[sprite_pixel_collision] ERROR");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        rsp_if.ready     = 1'b0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_LOAD_A;
        req_if.row_index = '0;
        req_if.row_bits  = '0;
        req_if.ax        = '0;
        req_if.ay        = '0;
        req_if.aw        = '0;
        req_if.ah        = '0;
        req_if.bx        = '0;
        req_if.by        = '0;
        req_if.bw        = '0;
        req_if.bh        = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // every mask row is written before any test reads it
        for (int r = 0; r < MAX_H; r++)
        begin
            drive(load_item(MODE_LOAD_A, r, rand_row()));
            drive(load_item(MODE_LOAD_B, r, rand_row()));
        end

        drive(load_item(MODE_LOAD_A, 0, 16'hFFFF));
        drive(load_item(MODE_LOAD_B, 0, 16'hFFFF));
        drive(test_item(0, 0, 16, 16, 0, 0, 16, 16));
        drive(test_item(-512, -512, 16, 16, 511, 511, 16, 16));
        drive(test_item(511, 511, 16, 16, -512, -512, 16, 16));
        drive(test_item(0, 0, 0, 16, 0, 0, 16, 16));
        drive(test_item(0, 0, 16, 0, 0, 0, 16, 16));
        drive(test_item(0, 0, 16, 16, 0, 0, 0, 16));
        drive(test_item(0, 0, 16, 16, 0, 0, 16, 0));
        drive(test_item(-8, -8, 31, 31, -3, -10, 17, 31));
        // set bits past A's width must not count
        drive(load_item(MODE_LOAD_A, 1, 16'hFFF0));
        drive(test_item(10, 0, 4, 2, 12, 1, 16, 1));
        drive(noise_item() | {MODE_NONE, {($bits(sprite_item_t) - MODE_W){1'b0}}});
        drive(test_item(-5, -5, 8, 8, -3, -4, 8, 8));
        drive(test_item(-512, 511, 16, 1, -512, 511, 16, 1));
        drive(load_item(MODE_LOAD_A, 15, 16'h8000));
        drive(load_item(MODE_LOAD_B, 15, 16'h0001));
        drive(test_item(100, 0, 16, 16, 85, 0, 16, 16));
        drive(test_item(100, 0, 16, 16, 115, 0, 16, 16));
        drive(test_item(100, 0, 16, 16, 116, 0, 16, 16));
        drive(test_item(100, -15, 16, 16, 85, 0, 16, 16));
        drive(test_item(511, 0, 31, 17, -512, 0, 31, 17));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i % 500 == 250)
                drain();
            drive(random_item());
        end

        drain();
        repeat (40) @(negedge clk);

        $display("Covered %0d collision tests (%0d predicted hits), %0d row loads,",
                 n_tests, hits_predicted, n_loads);
        $display("and %0d dropped mode-three items under random stalls on both sides.",
                 n_dropped);
        if (fail_count == 0)
            $display("[sprite_pixel_collision] OK");
        else
            $display("[sprite_pixel_collision] ERROR");
        $finish;
    end

endmodule
